// ===== hw/rtl/fdaf_pkg.sv =====
// ----------------------------------------------------------------------------
// fdaf_pkg
// shared constants, types and helpers of the fixed-point decimal text formatter
// ----------------------------------------------------------------------------
package fdaf_pkg;

    localparam int VALUE_W         = 32;
    localparam int TEXT_W          = 8;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int SIG_DIGITS_DEF  = 6;

    localparam logic [TEXT_W-1:0] ASCII_ZERO  = 8'd48;
    localparam logic [TEXT_W-1:0] ASCII_DOT   = 8'h2E;
    localparam logic [TEXT_W-1:0] ASCII_MINUS = 8'h2D;
    localparam logic [TEXT_W-1:0] ASCII_NL    = 8'd10;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIGN,
        ST_SKIP,
        ST_INT,
        ST_DOT,
        ST_FRAC,
        ST_NL
    } fdaf_state_t;

    // control from the sequencer to the digit units
    typedef struct packed {
        logic load;
        logic conv;
        logic int_shift;
        logic frac_step;
    } fdaf_ctrl_t;

    // decimal digits needed for an unsigned number of the given width
    function automatic int dec_digits(input int bits);
        longint unsigned lim;
        longint unsigned p;
        int n;
        lim = (64'd1 << bits) - 64'd1;
        n   = 1;
        p   = 64'd10;
        for (int i = 0; i < 20; i++) begin
            if (p <= lim) begin
                n = n + 1;
                p = p * 64'd10;
            end
        end
        return n;
    endfunction

endpackage

// ===== hw/rtl/fdaf_bcd_unit.sv =====
// ----------------------------------------------------------------------------
// fdaf_bcd_unit
// bit-serial binary to bcd conversion of the integer part, then digit shift-out
// ----------------------------------------------------------------------------
module fdaf_bcd_unit #(
    parameter int INT_W = 16,
    parameter int NDIG  = 5
) (
    input  logic                   aclk,
    input  fdaf_pkg::fdaf_ctrl_t   ctrl,
    input  logic [INT_W-1:0]       int_in,
    output logic [3:0]             top_digit
);
    import fdaf_pkg::*;

    localparam int BCD_W = NDIG * 4;

    logic [BCD_W-1:0] bcd_reg;
    logic [BCD_W-1:0] bcd_next;
    logic [INT_W-1:0] bin_reg;
    logic [INT_W-1:0] bin_next;
    logic [BCD_W-1:0] adj;

    // add-3 correction on every digit of 5 or more before the shift
    always_comb begin
        adj = bcd_reg;
        for (int i = 0; i < NDIG; i++) begin
            if (bcd_reg[i*4 +: 4] >= 4'd5) begin
                adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd3;
            end
        end
    end

    always_comb begin
        bcd_next = bcd_reg;
        bin_next = bin_reg;
        if (ctrl.load) begin
            bcd_next = '0;
            bin_next = int_in;
        end else if (ctrl.conv) begin
            bcd_next = {adj[BCD_W-2:0], bin_reg[INT_W-1]};
            bin_next = {bin_reg[INT_W-2:0], 1'b0};
        end else if (ctrl.int_shift) begin
            bcd_next = {bcd_reg[BCD_W-5:0], 4'b0000};
        end
    end

    always_ff @(posedge aclk) begin
        bcd_reg <= bcd_next;
        bin_reg <= bin_next;
    end

    assign top_digit = bcd_reg[BCD_W-1 -: 4];

endmodule

// ===== hw/rtl/fdaf_frac_unit.sv =====
// ----------------------------------------------------------------------------
// fdaf_frac_unit
// fraction digits by repeated multiply by ten, one truncated digit per step
// ----------------------------------------------------------------------------
module fdaf_frac_unit #(
    parameter int FW = 16
) (
    input  logic                   aclk,
    input  fdaf_pkg::fdaf_ctrl_t   ctrl,
    input  logic [FW-1:0]          frac_in,
    output logic [3:0]             digit
);
    import fdaf_pkg::*;

    logic [FW-1:0] rem_reg;
    logic [FW-1:0] rem_next;
    logic [FW+3:0] prod;

    // times ten as shift and add
    assign prod  = {1'b0, rem_reg, 3'b000} + {3'b000, rem_reg, 1'b0};
    assign digit = prod[FW+3:FW];

    always_comb begin
        rem_next = rem_reg;
        if (ctrl.load) begin
            rem_next = frac_in;
        end else if (ctrl.frac_step) begin
            rem_next = prod[FW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
    end

endmodule

// ===== hw/rtl/fdaf_out_stage.sv =====
// ----------------------------------------------------------------------------
// fdaf_out_stage
// output register of the text channel
// ----------------------------------------------------------------------------
module fdaf_out_stage (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    input  logic [fdaf_pkg::TEXT_W-1:0]   in_text,
    input  logic                          in_last,
    output logic                          in_ready,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [fdaf_pkg::TEXT_W-1:0]   m_text_byte,
    output logic                          m_last_byte
);
    import fdaf_pkg::*;

    logic              valid_reg;
    logic [TEXT_W-1:0] text_reg;
    logic              last_reg;

    assign in_ready = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_valid && in_ready) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            text_reg <= in_text;
            last_reg <= in_last;
        end
    end

    assign m_valid     = valid_reg;
    assign m_text_byte = text_reg;
    assign m_last_byte = last_reg;

endmodule

// ===== hw/rtl/fixed_decimal_ascii_formatter_core.sv =====
// ----------------------------------------------------------------------------
// fixed_decimal_ascii_formatter_core
// signed fixed-point value to ascii decimal text, one character per beat
// ----------------------------------------------------------------------------
// usage
//   input channel s_*: one signed value per beat, FRAC_BITS fractional bits
//   output channel m_*: one ascii character per beat, m_last_byte on the
//     closing newline; text is optional '-', integer digits without leading
//     zeros, '.', truncated fraction digits, newline
//   a zero value is taken and gives no output beat
//   one value at a time: s_ready is high only while the sequencer is idle
//   steps per value: accept, bit-serial bcd conversion of the INT_W =
//     32 - FRAC_BITS integer bits, the minus sign if any, leading zero
//     skip (NDIG integer digit places, D digits shown), then the other
//     characters, each held until the output register takes it
//   the output register lets the sequencer run ahead by one character;
//   a stall on m_ready holds the sequencer, nothing is dropped
//   reset (aresetn low, synchronous) returns to idle and empties the
//   output register
// ----------------------------------------------------------------------------
module fixed_decimal_ascii_formatter_core #(
    parameter int FRAC_BITS  = fdaf_pkg::FRAC_BITS_DEF,
    parameter int SIG_DIGITS = fdaf_pkg::SIG_DIGITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [fdaf_pkg::VALUE_W-1:0]  s_value_in,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [fdaf_pkg::TEXT_W-1:0]          m_text_byte,
    output logic                                 m_last_byte
);
    import fdaf_pkg::*;

    localparam int INT_W  = VALUE_W - FRAC_BITS;
    localparam int FW     = (FRAC_BITS > 0) ? FRAC_BITS : 1;
    localparam int NDIG   = dec_digits(INT_W);
    localparam int BCW    = $clog2(INT_W);
    localparam int ICW    = $clog2(NDIG + 1);
    localparam int FCW    = $clog2(SIG_DIGITS + 1);
    localparam int CMP_W  = (ICW > FCW) ? ICW : FCW;

    // magnitude of the incoming value, exact also for the most negative one
    logic [VALUE_W-1:0] raw;
    logic [VALUE_W-1:0] mag;
    logic [INT_W-1:0]   int_part;
    logic [FW-1:0]      frac_part;

    assign raw       = unsigned'(s_value_in);
    assign mag       = raw[VALUE_W-1] ? (~raw + VALUE_W'(1)) : raw;
    assign int_part  = mag[VALUE_W-1 -: INT_W];
    assign frac_part = (FRAC_BITS > 0) ? mag[FW-1:0] : '0;

    fdaf_state_t    state_reg;
    fdaf_state_t    state_next;
    logic [BCW-1:0] bit_cnt_reg;
    logic [BCW-1:0] bit_cnt_next;
    logic [ICW-1:0] int_left_reg;
    logic [ICW-1:0] int_left_next;
    logic [FCW-1:0] frac_left_reg;
    logic [FCW-1:0] frac_left_next;
    logic           neg_reg;
    logic           neg_next;

    fdaf_ctrl_t     ctrl;
    logic [3:0]     int_digit;
    logic [3:0]     frac_digit;
    logic           emit_valid;
    logic           emit_ready;
    logic [TEXT_W-1:0] emit_text;
    logic           emit_last;
    logic           in_beat;

    // fraction digit count: places minus shown integer digits, none if negative
    logic [FCW-1:0]   places;
    logic [CMP_W-1:0] places_ext;
    logic [CMP_W-1:0] dig_ext;
    logic [FCW-1:0]   frac_count;

    assign places     = neg_reg ? FCW'(SIG_DIGITS - 1) : FCW'(SIG_DIGITS);
    assign places_ext = CMP_W'(places);
    assign dig_ext    = CMP_W'(int_left_reg);
    assign frac_count = (dig_ext < places_ext) ? FCW'(places_ext - dig_ext) : '0;

    assign in_beat = s_valid && s_ready;

    // ---------------------------------------------------------------- digit units
    fdaf_bcd_unit #(
        .INT_W (INT_W),
        .NDIG  (NDIG)
    ) u_bcd (
        .aclk      (aclk),
        .ctrl      (ctrl),
        .int_in    (int_part),
        .top_digit (int_digit)
    );

    fdaf_frac_unit #(
        .FW (FW)
    ) u_frac (
        .aclk    (aclk),
        .ctrl    (ctrl),
        .frac_in (frac_part),
        .digit   (frac_digit)
    );

    fdaf_out_stage u_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (emit_valid),
        .in_text     (emit_text),
        .in_last     (emit_last),
        .in_ready    (emit_ready),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_text_byte (m_text_byte),
        .m_last_byte (m_last_byte)
    );

    // ---------------------------------------------------------------- next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_beat && (raw != '0)) begin
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                if (bit_cnt_reg == '0) begin
                    state_next = neg_reg ? ST_SIGN : ST_SKIP;
                end
            end
            ST_SIGN: begin
                if (emit_ready) begin
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP: begin
                // integer part zero leads straight to the point
                if (int_left_reg == '0) begin
                    state_next = ST_DOT;
                end else if (int_digit != 4'd0) begin
                    state_next = ST_INT;
                end
            end
            ST_INT: begin
                if (emit_ready && (int_left_reg == ICW'(1))) begin
                    state_next = ST_DOT;
                end
            end
            ST_DOT: begin
                if (emit_ready) begin
                    state_next = (frac_left_reg != '0) ? ST_FRAC : ST_NL;
                end
            end
            ST_FRAC: begin
                if (emit_ready && (frac_left_reg == FCW'(1))) begin
                    state_next = ST_NL;
                end
            end
            ST_NL: begin
                if (emit_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------- outputs
    always_comb begin
        s_ready        = 1'b0;
        ctrl           = '0;
        emit_valid     = 1'b0;
        emit_text      = ASCII_NL;
        emit_last      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready   = 1'b1;
                ctrl.load = in_beat;
            end
            ST_CONV: begin
                ctrl.conv = 1'b1;
            end
            ST_SIGN: begin
                emit_valid = 1'b1;
                emit_text  = ASCII_MINUS;
            end
            ST_SKIP: begin
                // drop leading zero digits without a beat
                ctrl.int_shift = (int_left_reg != '0) && (int_digit == 4'd0);
            end
            ST_INT: begin
                emit_valid     = 1'b1;
                emit_text      = ASCII_ZERO + {4'b0000, int_digit};
                ctrl.int_shift = emit_ready;
            end
            ST_DOT: begin
                emit_valid = 1'b1;
                emit_text  = ASCII_DOT;
            end
            ST_FRAC: begin
                emit_valid     = 1'b1;
                emit_text      = ASCII_ZERO + {4'b0000, frac_digit};
                ctrl.frac_step = emit_ready;
            end
            ST_NL: begin
                emit_valid = 1'b1;
                emit_text  = ASCII_NL;
                emit_last  = 1'b1;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // ---------------------------------------------------------------- counters
    always_comb begin
        bit_cnt_next   = bit_cnt_reg;
        int_left_next  = int_left_reg;
        frac_left_next = frac_left_reg;
        neg_next       = neg_reg;
        if (state_reg == ST_IDLE) begin
            if (in_beat) begin
                bit_cnt_next  = BCW'(INT_W - 1);
                int_left_next = ICW'(NDIG);
                neg_next      = raw[VALUE_W-1];
            end
        end else if (state_reg == ST_CONV) begin
            bit_cnt_next = bit_cnt_reg - BCW'(1);
        end else if (state_reg == ST_SKIP) begin
            if (ctrl.int_shift) begin
                int_left_next = int_left_reg - ICW'(1);
            end else begin
                // shown integer digits are known here
                frac_left_next = frac_count;
            end
        end else if (state_reg == ST_INT) begin
            if (ctrl.int_shift) begin
                int_left_next = int_left_reg - ICW'(1);
            end
        end else if (state_reg == ST_FRAC) begin
            if (ctrl.frac_step) begin
                frac_left_next = frac_left_reg - FCW'(1);
            end
        end
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            bit_cnt_reg   <= '0;
            int_left_reg  <= '0;
            frac_left_reg <= '0;
            neg_reg       <= 1'b0;
        end else begin
            state_reg     <= state_next;
            bit_cnt_reg   <= bit_cnt_next;
            int_left_reg  <= int_left_next;
            frac_left_reg <= frac_left_next;
            neg_reg       <= neg_next;
        end
    end

    // ---------------------------------------------------------------- checks
    // every character is a digit, point, minus or newline
    a_char_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_text_byte >= ASCII_ZERO) && (m_text_byte <= ASCII_ZERO + 8'd9))
                    || (m_text_byte == ASCII_DOT) || (m_text_byte == ASCII_MINUS)
                    || (m_text_byte == ASCII_NL))
        else $error("illegal character on output");

    // the last flag marks the newline and nothing else
    a_last_nl: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last_byte) |-> (m_text_byte == ASCII_NL))
        else $error("last flag on a character other than newline");

    // a nonzero value closes the input right after it is taken (the sequencer keeps it closed until its text is done)
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_value_in != '0)) |=> !s_ready)
        else $error("input reopened while formatting");

endmodule
